[hdl/lalc_pkg.sv]
package lalc_pkg;

   // Default sizes of the slot store.
   localparam int ENTRIES_DEF   = 8;
   localparam int KEY_BYTES_DEF = 8;

   // Fixed field widths.
   localparam int IN_KEY_W   = 64;
   localparam int LIFE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int SLOT_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [LIFE_W-1:0] LIFE_MAX_RESET = 8'd8;
   localparam logic [LEN_W-1:0]  LEN_RESET      = 4'd8;

   // Register indexes, taken from paddr[2].
   localparam logic REG_LIFETIME_MAX   = 1'b0;
   localparam logic REG_COMPARE_LENGTH = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } lalc_state_type;

   // Search summary that walks down the row of slot cells.
   typedef struct packed {
      logic              hit_found;
      logic              zero_found;
      logic [LIFE_W-1:0] best_life;
   } lalc_scan_type;

   // Update broadcast from the controller to every slot cell.
   typedef struct packed {
      logic              commit;
      logic              hit;
      logic [LIFE_W-1:0] life_max;
   } lalc_commit_type;

endpackage

[hdl/lifetime_aged_lookup_cache_top.sv]
// Lookup cache that filters duplicate keys and replaces slots by age.
// Request channel (req_valid, req_stall, req_key) takes one key per transaction.
// Response channel (rsp_valid, rsp_stall, rsp_hit, rsp_slot) returns one result
// per key: hit set when the key was found, and the matched or filled slot.
// A search token walks the row of slot cells, one cell per cycle. When it leaves
// the last cell, the outcome is registered, the slot update is made and the
// result is loaded into the output register. A new key is taken only once that
// update is done, so keys are not overlapped.
// The APB port holds lifetime_max at address 0 and compare_length at address 4.
// Write them only while the block is idle.
// Reset clears every stored key and lifetime at once, sets lifetime_max and
// compare_length to 8, and drops any transaction in flight. No clearing pass
// is needed, so the block can take a key as soon as reset is released.
// When the receiver stalls, the result holds in the output register. A new key
// may still be accepted and searched, but its slot update waits until the
// pending result has been taken.
module lifetime_aged_lookup_cache_top import lalc_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IN_KEY_W-1:0]   req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [SLOT_W-1:0]     rsp_slot,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int IDX_W = $clog2(ENTRIES);

   lalc_state_type    state_ff, state_in;
   logic [LIFE_W-1:0] life_max_ff, life_max_in;
   logic [LEN_W-1:0]  cmp_len_ff, cmp_len_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  mask_ff, mask_in;
   logic [LEN_W-1:0]  eff_len;
   logic              start_ff, start_in;
   logic              res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              accept;
   logic              capture;
   logic              csr_write;
   lalc_commit_type   cmt;

   // Search chain: element 0 is the token injected by the controller.
   logic [ENTRIES:0]  tok_vld;
   lalc_scan_type     tok_scan     [ENTRIES+1];
   logic [IDX_W-1:0]  tok_hit_idx  [ENTRIES+1];
   logic [IDX_W-1:0]  tok_zero_idx [ENTRIES+1];
   logic [IDX_W-1:0]  tok_best_idx [ENTRIES+1];

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      life_max_in = life_max_ff;
      cmp_len_in  = cmp_len_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_LIFETIME_MAX:   life_max_in = pwdata[LIFE_W-1:0];
            REG_COMPARE_LENGTH: cmp_len_in  = pwdata[LEN_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LIFETIME_MAX:   prdata = CSR_DATA_W'(life_max_ff);
         REG_COMPARE_LENGTH: prdata = CSR_DATA_W'(cmp_len_ff);
         default:            prdata = '0;
      endcase
   end

   // Byte mask of the compared key bytes, limited to the stored width.
   assign eff_len = (cmp_len_ff > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : cmp_len_ff;

   always_comb begin
      for (int b = 0; b < KEY_BYTES; b++) begin
         mask_in[b*8 +: 8] = {8{LEN_W'(b) < eff_len}};
      end
   end

   // Controller: next state, handshake and slot update broadcast.
   always_comb begin
      state_in     = state_ff;
      req_stall    = (state_ff != ST_IDLE);
      accept       = 1'b0;
      capture      = 1'b0;
      cmt.commit   = 1'b0;
      cmt.hit      = res_hit_ff;
      cmt.life_max = life_max_ff;
      unique case (state_ff)
         ST_IDLE: begin
            accept = req_valid;
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok_vld[ENTRIES]) begin
               capture  = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmt.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Search outcome: first hit, else first empty slot, else first oldest slot.
   always_comb begin
      res_hit_in = res_hit_ff;
      res_idx_in = res_idx_ff;
      if (capture) begin
         res_hit_in = tok_scan[ENTRIES].hit_found;
         if (tok_scan[ENTRIES].hit_found) begin
            res_idx_in = tok_hit_idx[ENTRIES];
         end else if (tok_scan[ENTRIES].zero_found) begin
            res_idx_in = tok_zero_idx[ENTRIES];
         end else begin
            res_idx_in = tok_best_idx[ENTRIES];
         end
      end
   end

   assign key_in   = accept ? req_key[KEY_W-1:0] : key_ff;
   assign start_in = accept;

   // Output register, loaded when the slot update happens.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (cmt.commit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res_hit_ff;
         rsp_slot_in  = SLOT_W'(res_idx_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         life_max_ff  <= LIFE_MAX_RESET;
         cmp_len_ff   <= LEN_RESET;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         life_max_ff  <= life_max_in;
         cmp_len_ff   <= cmp_len_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      mask_ff     <= accept ? mask_in : mask_ff;
      res_hit_ff  <= res_hit_in;
      res_idx_ff  <= res_idx_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_slot  = rsp_slot_ff;

   // Token injected at the head of the row.
   assign tok_vld[0]              = start_ff;
   assign tok_scan[0].hit_found   = 1'b0;
   assign tok_scan[0].zero_found  = 1'b0;
   assign tok_scan[0].best_life   = '1;
   assign tok_hit_idx[0]          = '0;
   assign tok_zero_idx[0]         = '0;
   assign tok_best_idx[0]         = '0;

   // Row of slot cells.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lalc_cell #(
         .ENTRIES   (ENTRIES),
         .KEY_BYTES (KEY_BYTES),
         .INDEX     (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (key_ff),
         .mask         (mask_ff),
         .in_valid     (tok_vld[i]),
         .in_scan      (tok_scan[i]),
         .in_hit_idx   (tok_hit_idx[i]),
         .in_zero_idx  (tok_zero_idx[i]),
         .in_best_idx  (tok_best_idx[i]),
         .out_valid    (tok_vld[i+1]),
         .out_scan     (tok_scan[i+1]),
         .out_hit_idx  (tok_hit_idx[i+1]),
         .out_zero_idx (tok_zero_idx[i+1]),
         .out_best_idx (tok_best_idx[i+1]),
         .cmt          (cmt),
         .cmt_idx      (res_idx_ff)
      );
   end

   // Only one search token is ever in the row.
   assert property (@(posedge clock) disable iff (reset) $onehot0(tok_vld))
      else $error("more than one search token in the slot row");

   // The token injected at the head is handed on to the first cell.
   assert property (@(posedge clock) disable iff (reset) tok_vld[0] |=> tok_vld[1])
      else $error("search token was not handed to the first cell");

   // A new key is taken only when no search is in progress.
   assert property (@(posedge clock) disable iff (reset) accept |-> (tok_vld == '0))
      else $error("key accepted while a search token is in the row");

   // A result appears only after a slot update.
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid_ff) |-> $past(cmt.commit))
      else $error("result presented without a slot update");

endmodule

[hdl/lalc_cell.sv]
module lalc_cell import lalc_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int INDEX     = 0,
   localparam int KEY_W    = 8 * KEY_BYTES,
   localparam int IDX_W    = $clog2(ENTRIES)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [KEY_W-1:0] key,
   input  logic [KEY_W-1:0] mask,
   input  logic            in_valid,
   input  lalc_scan_type   in_scan,
   input  logic [IDX_W-1:0] in_hit_idx,
   input  logic [IDX_W-1:0] in_zero_idx,
   input  logic [IDX_W-1:0] in_best_idx,
   output logic            out_valid,
   output lalc_scan_type   out_scan,
   output logic [IDX_W-1:0] out_hit_idx,
   output logic [IDX_W-1:0] out_zero_idx,
   output logic [IDX_W-1:0] out_best_idx,
   input  lalc_commit_type cmt,
   input  logic [IDX_W-1:0] cmt_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [LIFE_W-1:0] life_ff, life_in;
   logic              vld_ff;
   lalc_scan_type     scan_ff, scan_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  zero_idx_ff, zero_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              match;

   // This slot matches when the compared bytes agree.
   assign match = ((key_ff ^ key) & mask) == '0;

   // Fold this slot into the search summary handed to the next cell.
   always_comb begin
      scan_in     = in_scan;
      hit_idx_in  = in_hit_idx;
      zero_idx_in = in_zero_idx;
      best_idx_in = in_best_idx;
      if (!in_scan.hit_found && match) begin
         scan_in.hit_found = 1'b1;
         hit_idx_in        = MY_IDX;
      end
      if (!in_scan.zero_found && (life_ff == '0)) begin
         scan_in.zero_found = 1'b1;
         zero_idx_in        = MY_IDX;
      end
      if (life_ff < in_scan.best_life) begin
         scan_in.best_life = life_ff;
         best_idx_in       = MY_IDX;
      end
   end

   // Slot update: refresh on a hit, fill and age on a miss.
   always_comb begin
      key_in  = key_ff;
      life_in = life_ff;
      if (cmt.commit) begin
         if (cmt_idx == MY_IDX) begin
            if (cmt.hit) begin
               life_in = cmt.life_max;
            end else begin
               key_in  = (key_ff & ~mask) | (key & mask);
               life_in = (cmt.life_max == '0) ? '0 : cmt.life_max - LIFE_W'(1);
            end
         end else if (!cmt.hit && (life_ff != '0)) begin
            life_in = life_ff - LIFE_W'(1);
         end
      end
   end

   // Slot contents and the search token register.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         life_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         key_ff  <= key_in;
         life_ff <= life_in;
         vld_ff  <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      hit_idx_ff  <= hit_idx_in;
      zero_idx_ff <= zero_idx_in;
      best_idx_ff <= best_idx_in;
   end

   assign out_valid    = vld_ff;
   assign out_scan     = scan_ff;
   assign out_hit_idx  = hit_idx_ff;
   assign out_zero_idx = zero_idx_ff;
   assign out_best_idx = best_idx_ff;

endmodule
